// ===== hw/rtl/msc_pkg.sv =====
// Shared types and constants for the MSI snooping coherence block.
// No dependencies; imported by msi_snoop_coherence_top.
package msc_pkg;

  typedef enum logic [1:0] {
    ST_INV = 2'd0,
    ST_SHR = 2'd1,
    ST_MOD = 2'd2
  } msi_state_t;

  typedef enum logic {
    FUNC_RD = 1'b0,
    FUNC_WR = 1'b1
  } func_t;

  // field widths on the streaming ports
  localparam int CPU_W       = 2;
  localparam int BLK_W       = 8;
  localparam int MASK_W      = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // parameter defaults
  localparam int DEF_NUM_CPUS        = 4;
  localparam int DEF_LINES_PER_CACHE = 4;
  localparam int DEF_NUM_BLOCKS      = 256;

endpackage

// ===== hw/rtl/msi_snoop_coherence_top.sv =====
// MSI snooping coherence over NUM_CPUS direct-mapped private caches.
// Depends on msc_pkg (state encoding, field widths, parameter defaults).

// One access transaction is taken every cycle while the input is not stalled:
// the access lands in an input register, then all CPUs' lines at the
// indexed set are snooped in parallel and the line states are updated in the
// same cycle the result register loads. The next access therefore always sees
// the state left by the previous one. Back-pressure on the result side stalls
// the input only once both registers hold a transaction. Line states reset to
// invalid under synchronous reset; no clearing pass is needed.
module msi_snoop_coherence_top #(
  parameter int NUM_CPUS        = msc_pkg::DEF_NUM_CPUS,
  parameter int LINES_PER_CACHE = msc_pkg::DEF_LINES_PER_CACHE,
  parameter int NUM_BLOCKS      = msc_pkg::DEF_NUM_BLOCKS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [msc_pkg::IN_TDATA_W-1:0]  in_tdata,   // cpu[1:0], block[9:2], zero
  input  logic                            in_tuser,   // func
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // hit[0], new_state[2:1], evicted_valid[3], evicted_block[11:4],
  // shared_mask[15:12], invalidated_mask[19:16], zero
  output logic [msc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import msc_pkg::*;

  localparam int IDX_W  = (LINES_PER_CACHE > 1) ? $clog2(LINES_PER_CACHE) : 1;
  localparam int VEC_W  = (NUM_CPUS > MASK_W) ? NUM_CPUS : MASK_W;
  localparam int NTAB   = 1 << BLK_W;

  typedef logic [NTAB-1:0][BLK_W-1:0] blk_tab_t;
  typedef logic [NTAB-1:0][IDX_W-1:0] idx_tab_t;

  // block wrap and set index, resolved at elaboration
  function automatic blk_tab_t build_blk_tab();
    blk_tab_t t;
    for (int i = 0; i < NTAB; i++) t[i] = BLK_W'(i % NUM_BLOCKS);
    return t;
  endfunction

  function automatic idx_tab_t build_idx_tab();
    idx_tab_t t;
    for (int i = 0; i < NTAB; i++) t[i] = IDX_W'((i % NUM_BLOCKS) % LINES_PER_CACHE);
    return t;
  endfunction

  localparam blk_tab_t BLK_TAB = build_blk_tab();
  localparam idx_tab_t IDX_TAB = build_idx_tab();

  // ---------------- input register ----------------
  logic             in_v_r;
  logic [CPU_W-1:0] cpu_r;
  func_t            func_r;
  logic [BLK_W-1:0] blk_r;
  logic [IDX_W-1:0] idx_r;
  logic             adv;
  logic             proc;

  logic [BLK_W-1:0] in_block;
  assign in_block = in_tdata[CPU_W +: BLK_W];

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = !in_v_r || adv;
  assign proc      = in_v_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cpu_r  <= in_tdata[CPU_W-1:0];
      func_r <= func_t'(in_tuser);
      blk_r  <= BLK_TAB[in_block];
      idx_r  <= IDX_TAB[in_block];
    end
  end

  // ---------------- line storage ----------------
  msi_state_t       line_state_r [NUM_CPUS][LINES_PER_CACHE];
  logic [BLK_W-1:0] line_tag_r   [NUM_CPUS][LINES_PER_CACHE];

  // ---------------- snoop logic ----------------
  msi_state_t       st_c   [NUM_CPUS];
  logic [BLK_W-1:0] tag_c  [NUM_CPUS];
  logic [VEC_W-1:0] sel_vec;
  logic [VEC_W-1:0] hold_vec;
  logic [VEC_W-1:0] other_vec;   // other CPUs holding the block
  logic [VEC_W-1:0] mod_vec;
  logic             cpu_ok;
  msi_state_t       me_state;
  logic [BLK_W-1:0] me_tag;
  logic             hit;
  logic             ev_valid;
  logic [BLK_W-1:0] ev_block;
  msi_state_t       new_state;
  logic [MASK_W-1:0] sh_mask;
  logic [MASK_W-1:0] inv_mask;
  logic             upd;

  always_comb begin
    sel_vec   = '0;
    hold_vec  = '0;
    mod_vec   = '0;
    me_state  = ST_INV;
    me_tag    = '0;
    for (int c = 0; c < NUM_CPUS; c++) begin
      st_c[c]     = line_state_r[c][idx_r];
      tag_c[c]    = line_tag_r[c][idx_r];
      sel_vec[c]  = (int'(cpu_r) == c);
      hold_vec[c] = (st_c[c] != ST_INV) && (tag_c[c] == blk_r);
      mod_vec[c]  = hold_vec[c] && (st_c[c] == ST_MOD);
      if (sel_vec[c]) begin
        me_state = st_c[c];
        me_tag   = tag_c[c];
      end
    end
    cpu_ok    = (int'(cpu_r) < NUM_CPUS);
    other_vec = hold_vec & ~sel_vec;
    hit       = cpu_ok && (me_state != ST_INV) && (me_tag == blk_r);
    ev_valid  = cpu_ok && !hit && (me_state != ST_INV);
    ev_block  = ev_valid ? me_tag : '0;
    sh_mask   = '0;
    inv_mask  = '0;
    new_state = ST_INV;
    upd       = 1'b0;
    if (cpu_ok) begin
      if (func_r == FUNC_WR) begin
        inv_mask  = other_vec[MASK_W-1:0];
        new_state = ST_MOD;
        upd       = 1'b1;
      end else if (hit) begin
        new_state = me_state;
      end else begin
        sh_mask   = other_vec[MASK_W-1:0];
        new_state = ST_SHR;
        upd       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CPUS; c++) begin
        for (int l = 0; l < LINES_PER_CACHE; l++) line_state_r[c][l] <= ST_INV;
      end
    end else if (proc && upd) begin
      for (int c = 0; c < NUM_CPUS; c++) begin
        if (sel_vec[c]) begin
          line_state_r[c][idx_r] <= new_state;
        end else if (other_vec[c]) begin
          line_state_r[c][idx_r] <= (func_r == FUNC_WR) ? ST_INV : ST_SHR;
        end
      end
    end
  end

  // tags matter only while a line is valid
  always_ff @(posedge clk) begin
    if (proc && upd) begin
      for (int c = 0; c < NUM_CPUS; c++) begin
        if (sel_vec[c]) line_tag_r[c][idx_r] <= blk_r;
      end
    end
  end

  // ---------------- result register ----------------
  logic                   out_v_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;

  assign out_data_nxt = {4'b0, inv_mask, sh_mask, ev_block, ev_valid, new_state, hit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // ---------------- assertions ----------------
  // single writer: at most one modified copy of the accessed block
  a_single_mod: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r |-> $countones(mod_vec) <= 1)
    else $error("more than one modified copy of a block");

  a_masks_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:12] == '0) || (out_tdata[19:16] == '0))
    else $error("shared and invalidated masks both set");

  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[0])
    else $error("eviction reported on a hit");

  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:1] == ST_INV) |-> out_tdata == '0)
    else $error("invalid result state with nonzero fields");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back-pressure");

  a_write_mod: assert property (@(posedge clk) disable iff (!rst_n)
    proc && cpu_ok && (func_r == FUNC_WR) |=> out_tvalid && (out_tdata[2:1] == ST_MOD))
    else $error("write did not leave requester modified");

endmodule
